@@ rtl/ccsr_pkg.sv @@
package ccsr_pkg;

	// signed working coordinate, wide enough for apex +/- twice the half height
	typedef logic signed [10:0] coord_t;

	// row step inside one shape (diamond spans up to 2 * 127 + 1 rows)
	typedef logic [8:0] kidx_t;

	typedef enum logic [2:0] {
		CMD_PIXEL    = 3'd0,
		CMD_RECT     = 3'd1,
		CMD_DIAMOND  = 3'd2,
		CMD_TRI_UP   = 3'd3,
		CMD_TRI_DOWN = 3'd4,
		CMD_CLEAR    = 3'd5,
		CMD_READ     = 3'd6,
		CMD_NOP      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		OP_NONE  = 2'd0,
		OP_FILL  = 2'd1,
		OP_READ  = 2'd2,
		OP_CLEAR = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		SH_RECT    = 2'd0,
		SH_TRI     = 2'd1,
		SH_DIAMOND = 2'd2
	} shape_t;

	localparam logic [1:0] REG_NUM_ROWS = 2'd0;
	localparam logic [1:0] REG_NUM_COLS = 2'd1;

	localparam logic [7:0] DOT_CHAR  = 8'd46;
	localparam logic [6:0] DIM_RESET = 7'd64;

	// canvas bounds in use, as last valid index (may be -1 for an empty canvas)
	typedef struct packed {
		coord_t rows_m1;
		coord_t cols_m1;
	} limits_t;

	// classified command, handed from front to back
	typedef struct packed {
		op_t        op;
		shape_t     shape;
		logic       down;
		coord_t     row;
		coord_t     col;
		coord_t     width;
		kidx_t      half;
		kidx_t      k_lo;
		kidx_t      k_hi;
		logic [7:0] brush;
		logic       hit;
	} desc_t;

	typedef struct packed {
		logic [7:0] data;
		logic       hit;
	} result_t;

endpackage

@@ rtl/ccsr_ram.sv @@
module ccsr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/ccsr_fifo.sv @@
module ccsr_fifo #(
	parameter type T = logic,
	parameter int DEPTH = 2
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  T     wdata,
	output logic full,
	input  logic pop,
	output T     rdata,
	output logic empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	T              mem_q [DEPTH];
	logic [PW-1:0] wptr_q, rptr_q;
	logic [CW-1:0] cnt_q;
	logic          do_push, do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

endmodule

@@ rtl/ccsr_front.sv @@
module ccsr_front import ccsr_pkg::*; (
	input  logic              push,
	output logic              full,
	input  logic              q_full,
	input  logic              wiping,
	input  logic [2:0]        cmd,
	input  logic signed [7:0] col_pos,
	input  logic signed [7:0] row_pos,
	input  logic [6:0]        shape_width,
	input  logic [6:0]        shape_height,
	input  logic [7:0]        brush,
	input  limits_t           lim,
	output logic              enq,
	output desc_t             desc
);

	coord_t r, c, hh, ww;
	logic   pix_in;
	cmd_t   op_code;

	assign full    = q_full || wiping;
	assign enq     = push && !full;
	assign op_code = cmd_t'(cmd);

	assign r  = {{3{row_pos[7]}}, row_pos};
	assign c  = {{3{col_pos[7]}}, col_pos};
	assign hh = {4'b0, shape_height};
	assign ww = {4'b0, shape_width};

	assign pix_in = (r >= 0) && (r <= lim.rows_m1) && (c >= 0) && (c <= lim.cols_m1);

	always_comb begin
		coord_t n_m1, lo, hi;
		logic   is_fill, nonempty;

		desc       = '0;
		desc.op    = OP_NONE;
		desc.shape = SH_RECT;
		desc.row   = r;
		desc.col   = c;
		desc.width = ww;
		desc.half  = {2'b0, shape_height};
		desc.brush = brush;
		n_m1       = '0;
		is_fill    = 1'b0;
		nonempty   = 1'b0;

		unique case (op_code)
			CMD_PIXEL: begin
				is_fill    = 1'b1;
				nonempty   = pix_in;
				desc.width = coord_t'(1);
				desc.hit   = pix_in;
			end
			CMD_RECT: begin
				is_fill  = 1'b1;
				nonempty = (shape_width != '0) && (shape_height != '0);
				n_m1     = hh - coord_t'(1);
			end
			CMD_DIAMOND: begin
				is_fill    = 1'b1;
				nonempty   = 1'b1;
				desc.shape = SH_DIAMOND;
				n_m1       = hh + hh;
			end
			CMD_TRI_UP: begin
				is_fill    = 1'b1;
				nonempty   = (shape_height != '0);
				desc.shape = SH_TRI;
				n_m1       = hh - coord_t'(1);
			end
			CMD_TRI_DOWN: begin
				is_fill    = 1'b1;
				nonempty   = (shape_height != '0);
				desc.shape = SH_TRI;
				desc.down  = 1'b1;
				n_m1       = hh - coord_t'(1);
			end
			CMD_CLEAR: desc.op = OP_CLEAR;
			CMD_READ: begin
				desc.op  = OP_READ;
				desc.hit = pix_in;
			end
			CMD_NOP: desc.op = OP_NONE;
		endcase

		// clip the row steps to the canvas so the back end never walks dead rows
		if (desc.down) begin
			lo = (r - lim.rows_m1 > 0) ? r - lim.rows_m1 : '0;
			hi = (r < n_m1) ? r : n_m1;
		end else begin
			lo = (r < 0) ? -r : '0;
			hi = (lim.rows_m1 - r < n_m1) ? lim.rows_m1 - r : n_m1;
		end
		desc.k_lo = lo[8:0];
		desc.k_hi = hi[8:0];

		if (is_fill && nonempty && (lo <= hi)) begin
			desc.op = OP_FILL;
		end
	end

endmodule

@@ rtl/ccsr_back.sv @@
module ccsr_back import ccsr_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  limits_t lim,
	input  logic    wipe,
	input  logic    desc_valid,
	input  desc_t   desc,
	output logic    desc_pop,
	input  logic    res_full,
	output logic    res_push,
	output result_t res,
	output logic    wiping
);

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_ROW   = 5'b00010,
		ST_SPAN  = 5'b00100,
		ST_READ  = 5'b01000,
		ST_CLEAR = 5'b10000
	} state_t;

	state_t        state_q, state_d;
	desc_t         d_q;
	logic          d_load;
	kidx_t         k_q, k_d;
	coord_t        row_q, row_d, j_q, j_d, jend_q, jend_d;
	logic [AW-1:0] cnt_q, cnt_d;
	logic          clr_cmd_q, clr_cmd_d;

	logic          we, re;
	logic [AW-1:0] waddr, raddr, span_addr;
	logic [7:0]    wdata, rdata;

	coord_t kk, row_c, a_s, lo_c, hi_c, j0, j1;
	kidx_t  a_c;
	logic   span_ok;

	ccsr_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_canvas (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign wiping    = (state_q == ST_CLEAR) && !clr_cmd_q;
	assign span_addr = AW'(int'(row_q) * MAX_COLS + int'(j_q));
	assign raddr     = AW'(int'(desc.row) * MAX_COLS + int'(desc.col));

	// span of the current row, clipped to the canvas columns
	assign kk    = {2'b0, k_q};
	assign row_c = d_q.down ? d_q.row - kk : d_q.row + kk;
	assign a_c   = (k_q <= d_q.half) ? k_q : kidx_t'({d_q.half, 1'b0} - k_q);
	assign a_s   = {2'b0, a_c};

	always_comb begin
		if (d_q.shape == SH_RECT) begin
			lo_c = d_q.col;
			hi_c = d_q.col + d_q.width - coord_t'(1);
		end else begin
			lo_c = d_q.col - a_s;
			hi_c = d_q.col + a_s;
		end
	end

	assign j0      = (lo_c < 0) ? '0 : lo_c;
	assign j1      = (hi_c > lim.cols_m1) ? lim.cols_m1 : hi_c;
	assign span_ok = (j0 <= j1);

	always_comb begin
		state_d   = state_q;
		k_d       = k_q;
		row_d     = row_q;
		j_d       = j_q;
		jend_d    = jend_q;
		cnt_d     = cnt_q;
		clr_cmd_d = clr_cmd_q;
		d_load    = 1'b0;
		desc_pop  = 1'b0;
		res_push  = 1'b0;
		res       = '0;
		re        = 1'b0;
		we        = 1'b0;
		waddr     = span_addr;
		wdata     = d_q.brush;

		unique case (state_q)
			ST_IDLE: begin
				// a command is taken only with a result slot free, so its result never waits
				if (desc_valid && !res_full) begin
					desc_pop = 1'b1;
					d_load   = 1'b1;
					unique case (desc.op)
						OP_NONE: begin
							res_push = 1'b1;
							res.hit  = desc.hit;
						end
						OP_FILL: begin
							k_d     = desc.k_lo;
							state_d = ST_ROW;
						end
						OP_READ: begin
							if (desc.hit) begin
								re      = 1'b1;
								state_d = ST_READ;
							end else begin
								res_push = 1'b1;
							end
						end
						OP_CLEAR: begin
							cnt_d     = '0;
							clr_cmd_d = 1'b1;
							state_d   = ST_CLEAR;
						end
					endcase
				end
			end
			ST_ROW: begin
				if (span_ok) begin
					row_d   = row_c;
					j_d     = j0;
					jend_d  = j1;
					state_d = ST_SPAN;
				end else if (k_q == d_q.k_hi) begin
					res_push = 1'b1;
					res.hit  = d_q.hit;
					state_d  = ST_IDLE;
				end else begin
					k_d = k_q + 1'b1;
				end
			end
			ST_SPAN: begin
				we = 1'b1;
				if (j_q == jend_q) begin
					if (k_q == d_q.k_hi) begin
						res_push = 1'b1;
						res.hit  = d_q.hit;
						state_d  = ST_IDLE;
					end else begin
						k_d     = k_q + 1'b1;
						state_d = ST_ROW;
					end
				end else begin
					j_d = j_q + coord_t'(1);
				end
			end
			ST_READ: begin
				res_push = 1'b1;
				res.data = rdata;
				res.hit  = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_CLEAR: begin
				we    = 1'b1;
				waddr = cnt_q;
				wdata = DOT_CHAR;
				if (cnt_q == AW'(DEPTH - 1)) begin
					res_push = clr_cmd_q;
					state_d  = ST_IDLE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase

		// register write restarts the wipe; the user must write it only while idle, the block does not enforce this
		if (wipe) begin
			state_d   = ST_CLEAR;
			cnt_d     = '0;
			clr_cmd_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			cnt_q     <= '0;
			clr_cmd_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			cnt_q     <= cnt_d;
			clr_cmd_q <= clr_cmd_d;
		end
	end

	always_ff @(posedge clk) begin
		if (d_load) begin
			d_q <= desc;
		end
		k_q    <= k_d;
		row_q  <= row_d;
		j_q    <= j_d;
		jend_q <= jend_d;
	end

endmodule

@@ rtl/char_canvas_shape_rasterizer_top.sv @@
// Character canvas rasterizer: a MAX_ROWS x MAX_COLS byte framebuffer (row-major,
// address row * MAX_COLS + col) of which num_rows x num_cols cells are in use.
// Requests enter through a queue-style port (push/full) and every request gives
// exactly one result through a second queue-style port (empty/pop), in order.
// A front classifier clips each shape's rows to the canvas and hands it through a
// two-deep request queue to the back end, which owns the single-write-port canvas
// memory and writes one pixel per cycle while it walks a row span. The back end
// takes each request in its idle state, where one that changes nothing gives its
// result and a read that hits issues the memory read, answered from the read
// state. A filled shape visits the row state for each canvas row it touches and
// the span state for each covered pixel inside the canvas; a clear writes all
// MAX_ROWS * MAX_COLS entries. After reset and after every write of num_rows or
// num_cols the canvas is wiped back to '.', one entry per cycle, with full held
// high throughout and the configuration port (always ready) taking writes. The
// user must write configuration only when the block is idle; it is not enforced.
module char_canvas_shape_rasterizer_top import ccsr_pkg::*; #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	// request side
	input  logic              push,
	output logic              full,
	input  logic [2:0]        cmd,
	input  logic signed [7:0] col_pos,
	input  logic signed [7:0] row_pos,
	input  logic [6:0]        shape_width,
	input  logic [6:0]        shape_height,
	input  logic [7:0]        brush,
	// result side
	output logic              empty,
	input  logic              pop,
	output logic [7:0]        read_data,
	output logic              in_bounds,
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [6:0]        cfg_data
);

	localparam coord_t MAX_R = coord_t'(MAX_ROWS);
	localparam coord_t MAX_C = coord_t'(MAX_COLS);

	logic [6:0] num_rows_q, num_cols_q;
	coord_t     nr, nc;
	limits_t    lim;
	logic       cfg_wr, wipe;

	desc_t   desc_in, desc_head;
	logic    enq, q_full, dq_empty, desc_pop;
	result_t res, res_head;
	logic    res_push, res_full;
	logic    wiping;

	// configuration registers; a write to either one resizes and wipes
	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign wipe      = cfg_wr && ((cfg_index == REG_NUM_ROWS) || (cfg_index == REG_NUM_COLS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_rows_q <= DIM_RESET;
			num_cols_q <= DIM_RESET;
		end else if (cfg_wr) begin
			if (cfg_index == REG_NUM_ROWS) begin
				num_rows_q <= cfg_data;
			end
			if (cfg_index == REG_NUM_COLS) begin
				num_cols_q <= cfg_data;
			end
		end
	end

	// sizes above the physical canvas fold to the physical size
	assign nr          = {4'b0, num_rows_q};
	assign nc          = {4'b0, num_cols_q};
	assign lim.rows_m1 = ((nr > MAX_R) ? MAX_R : nr) - coord_t'(1);
	assign lim.cols_m1 = ((nc > MAX_C) ? MAX_C : nc) - coord_t'(1);

	// front: accept and classify
	ccsr_front u_front (
		.push         (push),
		.full         (full),
		.q_full       (q_full),
		.wiping       (wiping),
		.cmd          (cmd),
		.col_pos      (col_pos),
		.row_pos      (row_pos),
		.shape_width  (shape_width),
		.shape_height (shape_height),
		.brush        (brush),
		.lim          (lim),
		.enq          (enq),
		.desc         (desc_in)
	);

	// request queue between front and back
	ccsr_fifo #(.T(desc_t), .DEPTH(2)) u_req_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (enq),
		.wdata  (desc_in),
		.full   (q_full),
		.pop    (desc_pop),
		.rdata  (desc_head),
		.empty  (dq_empty)
	);

	// back: rasterize, read, clear
	ccsr_back #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.lim        (lim),
		.wipe       (wipe),
		.desc_valid (!dq_empty),
		.desc       (desc_head),
		.desc_pop   (desc_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (res),
		.wiping     (wiping)
	);

	// result queue decouples the back end from the consumer
	ccsr_fifo #(.T(result_t), .DEPTH(2)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.wdata  (res),
		.full   (res_full),
		.pop    (pop),
		.rdata  (res_head),
		.empty  (empty)
	);

	assign read_data = res_head.data;
	assign in_bounds = res_head.hit;

endmodule

@@ rtl/ccsr_checker.sv @@
module ccsr_checker import ccsr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic [2:0]        cmd,
	input logic signed [7:0] col_pos,
	input logic signed [7:0] row_pos,
	input logic [6:0]        shape_width,
	input logic [6:0]        shape_height,
	input logic [7:0]        brush,
	input logic              empty,
	input logic              pop,
	input logic [7:0]        read_data,
	input logic              in_bounds,
	input logic              cfg_valid,
	input logic              cfg_ready,
	input logic [1:0]        cfg_index,
	input logic [6:0]        cfg_data
);

	// a resize wipes the canvas, so no request may enter right after it
	a_resize_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_ready && (cfg_index == REG_NUM_ROWS || cfg_index == REG_NUM_COLS))
		|=> full)
		else $error("request side open right after a resize");

	// a waiting result stays put until taken
	a_result_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(read_data) && $stable(in_bounds)))
		else $error("waiting result changed before pop");

	// data only comes back from a read that hit the canvas
	a_miss_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !in_bounds) |-> (read_data == 8'd0))
		else $error("nonzero data on an out-of-canvas result");

endmodule

bind char_canvas_shape_rasterizer_top ccsr_checker u_ccsr_checker (.*);
